/* hw/rtl/tqwl_pkg.sv */
// ----------------------------------------------------------------------------
// tqwl_pkg
// Shared types and codes of the token quota window limiter.
// ----------------------------------------------------------------------------
package tqwl_pkg;

   localparam int unsigned TOKEN_WIDTH = 32;

   // command codes on req_cmd
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH  = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOKEN_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TICKS = 1'b1;

   localparam logic [TOKEN_WIDTH-1:0] TOKEN_LIMIT_RESET = 32'd65535;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_CLEAR,
      OP_TICK,
      OP_NONE
   } op_kind_type;

   typedef enum logic [1:0] {
      STATUS_ADMIT = 2'd0,
      STATUS_DENY  = 2'd1,
      STATUS_NONE  = 2'd2
   } status_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [TOKEN_WIDTH-1:0] in_tokens;
      logic [TOKEN_WIDTH-1:0] out_tokens;
      logic [TOKEN_WIDTH:0]   req_sum;
   } op_type;

   typedef struct packed {
      status_type             status;
      logic [TOKEN_WIDTH-1:0] used_total;
      logic [TOKEN_WIDTH-1:0] input_total;
      logic [TOKEN_WIDTH-1:0] output_total;
      logic [TOKEN_WIDTH-1:0] remaining;
      logic [TOKEN_WIDTH-1:0] request_total;
      logic [TOKEN_WIDTH-1:0] denied_total;
   } rsp_type;

endpackage

/* hw/rtl/tqwl_fifo.sv */
// ----------------------------------------------------------------------------
// tqwl_fifo
// Small synchronous queue with registered storage; push and pop may
// happen in the same cycle. DEPTH must be a power of two; the block does not check this.
// ----------------------------------------------------------------------------
module tqwl_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_fill_tracks_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + (AW+1)'(1))
      else $error("queue fill level did not follow a lone push");

   a_fill_tracks_pop: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - (AW+1)'(1))
      else $error("queue fill level did not follow a lone pop");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue fill level above depth");
`endif

endmodule

/* hw/rtl/tqwl_front.sv */
// ----------------------------------------------------------------------------
// tqwl_front
// Input stage: takes request beats, decodes the command and forms the
// wide token sum of an add request before it enters the command queue.
// ----------------------------------------------------------------------------
module tqwl_front
   import tqwl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_cmd,
   input  logic [TOKEN_WIDTH-1:0] req_in_tokens,
   input  logic [TOKEN_WIDTH-1:0] req_out_tokens,
   output logic                   op_push,
   output op_type                 op,
   input  logic                   op_full
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;

   assign req_full = valid_ff && op_full;
   assign accept   = req_push && !req_full;
   assign op_push  = valid_ff;
   assign op       = op_ff;

   always_comb begin
      valid_in = accept || (valid_ff && op_full);

      unique case (req_cmd)
         CMD_ADD:   op_in.kind = OP_ADD;
         CMD_CLEAR: op_in.kind = OP_CLEAR;
         CMD_TICK:  op_in.kind = OP_TICK;
         default:   op_in.kind = OP_NONE;
      endcase
      op_in.in_tokens  = req_in_tokens;
      op_in.out_tokens = req_out_tokens;
      op_in.req_sum    = {1'b0, req_in_tokens} + {1'b0, req_out_tokens};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
   end

endmodule

/* hw/rtl/tqwl_back.sv */
// ----------------------------------------------------------------------------
// tqwl_back
// Execution stage: holds the limit, window and usage counters, decides
// admission of each queued add command and produces a result beat for every command.
// ----------------------------------------------------------------------------
module tqwl_back
   import tqwl_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TOKEN_WIDTH-1:0]     csr_wdata,
   input  logic                       op_valid,
   input  op_type                     op,
   output logic                       op_pop,
   input  logic                       rsp_full,
   output logic                       rsp_push,
   output rsp_type                    rsp
);

   // wide enough for limit minus usage minus request without wrap
   localparam int unsigned DW = ((COUNT_WIDTH > TOKEN_WIDTH + 1) ?
                                 COUNT_WIDTH : TOKEN_WIDTH + 1) + 2;
   localparam int unsigned XW = (COUNT_WIDTH > TOKEN_WIDTH) ? COUNT_WIDTH : TOKEN_WIDTH;

   logic [TOKEN_WIDTH-1:0] max_ff, max_in;
   logic [TOKEN_WIDTH-1:0] window_ff, window_in;
   logic [TOKEN_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] used_ff, used_in;
   logic [COUNT_WIDTH-1:0] input_ff, input_in;
   logic [COUNT_WIDTH-1:0] output_ff, output_in;
   logic [TOKEN_WIDTH-1:0] admitted_ff, admitted_in;
   logic [TOKEN_WIDTH-1:0] refused_ff, refused_in;

   logic [DW-1:0]          diff;
   logic                   fits;
   logic [XW-1:0]          used_x;
   logic [TOKEN_WIDTH-1:0] rem_hold;
   logic [TOKEN_WIDTH:0]   elapsed_inc;
   logic                   window_done;
   logic [XW-1:0]          used_in_x, input_in_x, output_in_x;
   status_type             status;
   logic [TOKEN_WIDTH-1:0] remaining;

   assign op_pop   = op_valid && !rsp_full;
   assign rsp_push = op_pop;

   // sign of limit - used - request decides admission
   assign diff = DW'(max_ff) - DW'(used_ff) - DW'(op.req_sum);
   assign fits = !diff[DW-1];

   assign used_x   = XW'(used_ff);
   assign rem_hold = (XW'(max_ff) > used_x) ? (max_ff - used_x[TOKEN_WIDTH-1:0]) : '0;

   assign elapsed_inc = {1'b0, elapsed_ff} + (TOKEN_WIDTH+1)'(1);
   assign window_done = (elapsed_inc >= {1'b0, window_ff});

   always_comb begin
      max_in      = max_ff;
      window_in   = window_ff;
      elapsed_in  = elapsed_ff;
      used_in     = used_ff;
      input_in    = input_ff;
      output_in   = output_ff;
      admitted_in = admitted_ff;
      refused_in  = refused_ff;
      status      = STATUS_NONE;
      remaining   = rem_hold;

      if (op_pop) begin
         unique case (op.kind)
            OP_ADD: begin
               if (fits) begin
                  used_in     = used_ff + COUNT_WIDTH'(op.req_sum);
                  input_in    = input_ff + COUNT_WIDTH'(op.in_tokens);
                  output_in   = output_ff + COUNT_WIDTH'(op.out_tokens);
                  admitted_in = admitted_ff + TOKEN_WIDTH'(1);
                  status      = STATUS_ADMIT;
                  remaining   = diff[TOKEN_WIDTH-1:0];
               end else begin
                  refused_in = refused_ff + TOKEN_WIDTH'(1);
                  status     = STATUS_DENY;
               end
            end
            OP_CLEAR: begin
               used_in   = '0;
               input_in  = '0;
               output_in = '0;
               remaining = max_ff;
            end
            OP_TICK: begin
               if (window_ff != '0) begin
                  if (window_done) begin
                     used_in    = '0;
                     input_in   = '0;
                     output_in  = '0;
                     elapsed_in = '0;
                     remaining  = max_ff;
                  end else begin
                     elapsed_in = elapsed_inc[TOKEN_WIDTH-1:0];
                  end
               end
            end
            OP_NONE: begin
            end
         endcase
      end

      // writing the window length restarts the window
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOKEN_LIMIT: begin
               max_in = csr_wdata;
            end
            CSR_WINDOW_TICKS: begin
               window_in  = csr_wdata;
               elapsed_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      used_in_x         = XW'(used_in);
      input_in_x        = XW'(input_in);
      output_in_x       = XW'(output_in);
      rsp.status        = status;
      rsp.used_total    = used_in_x[TOKEN_WIDTH-1:0];
      rsp.input_total   = input_in_x[TOKEN_WIDTH-1:0];
      rsp.output_total  = output_in_x[TOKEN_WIDTH-1:0];
      rsp.remaining     = remaining;
      rsp.request_total = admitted_in;
      rsp.denied_total  = refused_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff      <= TOKEN_LIMIT_RESET;
         window_ff   <= '0;
         elapsed_ff  <= '0;
         used_ff     <= '0;
         input_ff    <= '0;
         output_ff   <= '0;
         admitted_ff <= '0;
         refused_ff  <= '0;
      end else begin
         max_ff      <= max_in;
         window_ff   <= window_in;
         elapsed_ff  <= elapsed_in;
         used_ff     <= used_in;
         input_ff    <= input_in;
         output_ff   <= output_in;
         admitted_ff <= admitted_in;
         refused_ff  <= refused_in;
      end
   end

`ifndef SYNTHESIS
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      (window_ff != '0) |-> (elapsed_ff < window_ff))
      else $error("window tick count reached the window length");

   a_deny_keeps_usage: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind == OP_ADD && !fits) |=>
         (refused_ff == $past(refused_ff) + TOKEN_WIDTH'(1)) && (used_ff == $past(used_ff)))
      else $error("denied request changed usage or missed the denial count");

   a_no_decision_keeps_counts: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind != OP_ADD) |=>
         (admitted_ff == $past(admitted_ff)) && (refused_ff == $past(refused_ff)))
      else $error("command without decision changed request counters");
`endif

endmodule

/* hw/rtl/token_quota_window_limiter.sv */
// A result reaches the result ports through the front register, the command queue, the
// back stage and the result queue. Throughput: one request per cycle unless stalled; the
// back-stage usage update (limit minus usage minus request, then a sign test) is
// combinational. Stalls on the result side back up through a 2-entry result queue, a
// 4-entry command queue and the front register. Reset is synchronous: queues empty, all
// totals zero, token limit 65535, window length 0; no clearing pass.
// ----------------------------------------------------------------------------
// token_quota_window_limiter
// Fixed-window token quota admission: front stage decodes requests, a
// command queue decouples it from the back stage that keeps the totals.
// ----------------------------------------------------------------------------
module token_quota_window_limiter
   import tqwl_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_cmd,
   input  logic [TOKEN_WIDTH-1:0]     req_in_tokens,
   input  logic [TOKEN_WIDTH-1:0]     req_out_tokens,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [1:0]                 rsp_status,
   output logic [TOKEN_WIDTH-1:0]     rsp_used_total,
   output logic [TOKEN_WIDTH-1:0]     rsp_input_total,
   output logic [TOKEN_WIDTH-1:0]     rsp_output_total,
   output logic [TOKEN_WIDTH-1:0]     rsp_remaining,
   output logic [TOKEN_WIDTH-1:0]     rsp_request_total,
   output logic [TOKEN_WIDTH-1:0]     rsp_denied_total,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TOKEN_WIDTH-1:0]     csr_wdata
);

   localparam int unsigned OP_QUEUE_DEPTH  = 4;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   op_type  front_op;
   logic    front_push;
   logic    op_full;
   op_type  queue_op;
   logic    op_empty;
   logic    op_pop;
   rsp_type back_rsp;
   logic    back_push;
   logic    rsp_full;
   rsp_type rsp_head;

   tqwl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_in_tokens  (req_in_tokens),
      .req_out_tokens (req_out_tokens),
      .op_push        (front_push),
      .op             (front_op),
      .op_full        (op_full)
   );

   tqwl_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_op),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (queue_op),
      .empty     (op_empty)
   );

   tqwl_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (!op_empty),
      .op        (queue_op),
      .op_pop    (op_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp       (back_rsp)
   );

   tqwl_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_status        = rsp_head.status;
   assign rsp_used_total    = rsp_head.used_total;
   assign rsp_input_total   = rsp_head.input_total;
   assign rsp_output_total  = rsp_head.output_total;
   assign rsp_remaining     = rsp_head.remaining;
   assign rsp_request_total = rsp_head.request_total;
   assign rsp_denied_total  = rsp_head.denied_total;

endmodule

/* tb/token_quota_window_limiter_tb.sv */
// ----------------------------------------------------------------------------
// token_quota_window_limiter_tb
// Self-checking bench for the token quota window limiter: a queue-fed driver
// offers request beats, an in-bench quota predictor computes the response of
// every accepted beat, and a monitor compares each popped response field by
// field. Runs directed corner cases, then random phases under several limit
// and window settings with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module token_quota_window_limiter_tb;
   import tqwl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned NUM_PHASES = 8;
   localparam int unsigned PHASE_BEATS = 145;
   localparam int unsigned LONG_STALL_CYCLES = 120;

   typedef struct {
      logic [1:0]             cmd;
      logic [TOKEN_WIDTH-1:0] in_tok;
      logic [TOKEN_WIDTH-1:0] out_tok;
   } quota_req_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [1:0]                 req_cmd = CMD_ADD;
   logic [TOKEN_WIDTH-1:0]     req_in_tokens = '0;
   logic [TOKEN_WIDTH-1:0]     req_out_tokens = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [1:0]                 rsp_status;
   logic [TOKEN_WIDTH-1:0]     rsp_used_total;
   logic [TOKEN_WIDTH-1:0]     rsp_input_total;
   logic [TOKEN_WIDTH-1:0]     rsp_output_total;
   logic [TOKEN_WIDTH-1:0]     rsp_remaining;
   logic [TOKEN_WIDTH-1:0]     rsp_request_total;
   logic [TOKEN_WIDTH-1:0]     rsp_denied_total;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_TOKEN_LIMIT;
   logic [TOKEN_WIDTH-1:0]     csr_wdata = '0;

   // predictor state
   logic [TOKEN_WIDTH-1:0] quota_limit = TOKEN_LIMIT_RESET;
   logic [TOKEN_WIDTH-1:0] quota_window = '0;
   logic [TOKEN_WIDTH-1:0] tick_count = '0;
   logic [TOKEN_WIDTH-1:0] used_tok = '0;
   logic [TOKEN_WIDTH-1:0] in_tok_sum = '0;
   logic [TOKEN_WIDTH-1:0] out_tok_sum = '0;
   logic [TOKEN_WIDTH-1:0] admit_cnt = '0;
   logic [TOKEN_WIDTH-1:0] deny_cnt = '0;

   quota_req_type req_beat_q[$];
   rsp_type       quota_rsp_q[$];

   int unsigned beats_queued = 0;
   int unsigned beats_offered = 0;
   int unsigned beats_taken = 0;
   int unsigned errors = 0;
   int unsigned reg_writes = 0;
   int unsigned full_cycles = 0;
   int unsigned n_admit = 0;
   int unsigned n_deny = 0;
   int unsigned n_none = 0;
   bit          idle_on = 1'b1;
   bit          long_stall_req = 1'b0;
   int unsigned send_gap = 0;
   int unsigned rcv_gap = 0;
   int unsigned rcv_hold = 0;

   token_quota_window_limiter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_in_tokens     (req_in_tokens),
      .req_out_tokens    (req_out_tokens),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_used_total    (rsp_used_total),
      .rsp_input_total   (rsp_input_total),
      .rsp_output_total  (rsp_output_total),
      .rsp_remaining     (rsp_remaining),
      .rsp_request_total (rsp_request_total),
      .rsp_denied_total  (rsp_denied_total),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_usage();
      used_tok = '0;
      in_tok_sum = '0;
      out_tok_sum = '0;
   endfunction

   // admission decision and total update for one request beat
   function automatic rsp_type quota_step(input logic [1:0] cmd,
                                          input logic [TOKEN_WIDTH-1:0] itok,
                                          input logic [TOKEN_WIDTH-1:0] otok);
      logic [TOKEN_WIDTH+1:0] need;
      rsp_type r;
      r.status = STATUS_NONE;
      need = (TOKEN_WIDTH+2)'(itok) + (TOKEN_WIDTH+2)'(otok);
      case (cmd)
         CMD_ADD: begin
            // sum kept wide so huge requests never wrap into admission
            if ((TOKEN_WIDTH+2)'(used_tok) + need > (TOKEN_WIDTH+2)'(quota_limit)) begin
               deny_cnt++;
               r.status = STATUS_DENY;
            end else begin
               used_tok = used_tok + need[TOKEN_WIDTH-1:0];
               in_tok_sum = in_tok_sum + itok;
               out_tok_sum = out_tok_sum + otok;
               admit_cnt++;
               r.status = STATUS_ADMIT;
            end
         end
         CMD_CLEAR: clear_usage();
         CMD_TICK: begin
            if (quota_window != 0) begin
               tick_count++;
               if (tick_count >= quota_window) begin
                  clear_usage();
                  tick_count = '0;
               end
            end
         end
         default: ;
      endcase
      r.used_total = used_tok;
      r.input_total = in_tok_sum;
      r.output_total = out_tok_sum;
      r.remaining = (quota_limit > used_tok) ? quota_limit - used_tok : '0;
      r.request_total = admit_cnt;
      r.denied_total = deny_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [TOKEN_WIDTH-1:0] want,
                              input logic [TOKEN_WIDTH-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
   endtask

   // response check, then prediction of the beat taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (quota_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: response with nothing outstanding, expected none got status %0d",
                        $time, rsp_status);
            end else begin
               want = quota_rsp_q.pop_front();
               check_field("status", TOKEN_WIDTH'(want.status), TOKEN_WIDTH'(rsp_status));
               check_field("used_total", want.used_total, rsp_used_total);
               check_field("input_total", want.input_total, rsp_input_total);
               check_field("output_total", want.output_total, rsp_output_total);
               check_field("remaining", want.remaining, rsp_remaining);
               check_field("request_total", want.request_total, rsp_request_total);
               check_field("denied_total", want.denied_total, rsp_denied_total);
               case (want.status)
                  STATUS_ADMIT: n_admit++;
                  STATUS_DENY:  n_deny++;
                  default:      n_none++;
               endcase
            end
         end
         if (req_push && !req_full) begin
            quota_rsp_q.push_back(quota_step(req_cmd, req_in_tokens, req_out_tokens));
            beats_taken++;
         end
         if (req_push && req_full)
            full_cycles++;
      end
   end

   // request driver
   always @(negedge clock) begin
      quota_req_type beat;
      if (!reset && !(req_push && beats_taken != beats_offered)) begin
         if (req_push && idle_on && $urandom_range(0, 11) == 0)
            send_gap = $urandom_range(1, 18);
         if (send_gap != 0 || req_beat_q.size() == 0) begin
            req_push <= 1'b0;
            if (send_gap != 0)
               send_gap--;
         end else begin
            beat = req_beat_q.pop_front();
            req_cmd <= beat.cmd;
            req_in_tokens <= beat.in_tok;
            req_out_tokens <= beat.out_tok;
            req_push <= 1'b1;
            beats_offered++;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (long_stall_req) begin
         rcv_hold = LONG_STALL_CYCLES;
         long_stall_req = 1'b0;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rcv_hold != 0) begin
         rcv_hold--;
         rsp_pop <= 1'b0;
      end else if (rcv_gap != 0) begin
         rcv_gap--;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         rcv_gap = $urandom_range(0, 17);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic queue_beat(input logic [1:0] cmd, input logic [TOKEN_WIDTH-1:0] itok,
                             input logic [TOKEN_WIDTH-1:0] otok);
      quota_req_type beat;
      beat.cmd = cmd;
      beat.in_tok = itok;
      beat.out_tok = otok;
      req_beat_q.push_back(beat);
      beats_queued++;
   endtask

   task automatic drain_all();
      while (beats_taken != beats_queued || quota_rsp_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [TOKEN_WIDTH-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_TOKEN_LIMIT) begin
         quota_limit = val;
      end else begin
         // a window write restarts the window
         quota_window = val;
         tick_count = '0;
      end
      reg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [TOKEN_WIDTH-1:0] pick_tokens(input logic [TOKEN_WIDTH-1:0] lim);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         default: return $urandom_range(0, (lim >> 3) + 1);
      endcase
   endfunction

   task automatic queue_random_beat(input logic [TOKEN_WIDTH-1:0] lim);
      int unsigned pick;
      logic [1:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         cmd = CMD_ADD;
      else if (pick < 76)
         cmd = CMD_CLEAR;
      else if (pick < 95)
         cmd = CMD_TICK;
      else
         cmd = CMD_UNUSED;
      queue_beat(cmd, pick_tokens(lim), pick_tokens(lim));
   endtask

   initial begin
      logic [TOKEN_WIDTH-1:0] limits [NUM_PHASES];
      logic [TOKEN_WIDTH-1:0] windows [NUM_PHASES];
      limits = '{32'd1, 32'd16, 32'd1000, 32'hFFFF_FFFF, $urandom, 32'd65535, 32'd4096,
                 $urandom_range(2, 300)};
      windows = '{32'd0, 32'd1, 32'd5, 32'hFFFF_FFFF, $urandom_range(1, 40), 32'd0, 32'd2,
                  32'd3};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset settings: limit 65535, windowing off
      queue_beat(CMD_ADD, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd65535, 32'd0);
      queue_beat(CMD_ADD, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd1, 32'd0);
      queue_beat(CMD_ADD, 32'd0, 32'd1);
      queue_beat(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(CMD_TICK, 32'd1234, 32'd5678);
      queue_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(CMD_ADD, 32'hFFFF_FFFF, 32'd0);
      queue_beat(CMD_ADD, 32'd100, 32'd200);
      drain_all();

      // full-range limit, short window; clear keeps the tick count
      write_reg(CSR_TOKEN_LIMIT, 32'hFFFF_FFFF);
      write_reg(CSR_WINDOW_TICKS, 32'd3);
      queue_beat(CMD_CLEAR, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_beat(CMD_ADD, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd1, 32'd0);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_CLEAR, 32'd7, 32'd9);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd10, 32'd20);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd5, 32'd5);
      drain_all();

      // limit dropped below current usage
      write_reg(CSR_TOKEN_LIMIT, 32'd16);
      queue_beat(CMD_ADD, 32'd0, 32'd0);
      queue_beat(CMD_TICK, 32'd0, 32'd0);
      queue_beat(CMD_ADD, 32'd16, 32'd0);
      drain_all();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_TOKEN_LIMIT, limits[p]);
         write_reg(CSR_WINDOW_TICKS, windows[p]);
         if (p == NUM_PHASES - 1)
            idle_on = 1'b0;
         if (p == 1)
            long_stall_req = 1'b1;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // sender pause: let everything outstanding come back first
            if (p == 3 && i == PHASE_BEATS / 2)
               drain_all();
            queue_random_beat(limits[p]);
         end
         drain_all();
      end

      $display("covered %0d request beats over %0d register writes, %0d cycles input held off",
               beats_taken, reg_writes, full_cycles);
      $display("responses: %0d admitted, %0d denied, %0d without decision",
               n_admit, n_deny, n_none);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d beats still outstanding", quota_rsp_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
